>>> design/size_sorted_block_allocator_unit_macros.svh
// Assertion macros for the size sorted block allocator.
// Included by the top level; expects a clock named clk and a reset named rst.
`ifndef SIZE_SORTED_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define SIZE_SORTED_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define SSBA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SSBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> design/ssba_pkg.sv
// Package for the size sorted block allocator: field widths, codes and types.
// Used by ssba_cell and size_sorted_block_allocator_unit.
`timescale 1ns / 1ps
`default_nettype none
package ssba_pkg;
  localparam int ADDR_W = 32;
  localparam int SIZE_W = 27;
  localparam int CNT_OUT_W = 7;
  localparam int DEF_MAX_BLOCKS = 64;
  localparam int DEF_HEADER_BYTES = 32;
  localparam logic [SIZE_W-1:0] SIZE_CAP = 27'd100000000;
  localparam logic [ADDR_W-1:0] HEAP_BASE_RST = 32'd65536;
  localparam logic [ADDR_W-1:0] HEAP_LIMIT_RST = 32'd16777216;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_RESIZE = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD_SIZE = 2'd1;
  localparam logic [1:0] ST_NO_ROOM = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  localparam logic CFG_HEAP_BASE = 1'b0;
  localparam logic CFG_HEAP_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EVAL,
    FSM_ACT,
    FSM_FREE
  } fsm_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_MARK_USED,
    CELL_MARK_FREE,
    CELL_LOAD_NEW,
    CELL_TAKE_LEFT
  } cell_op_t;

  typedef struct packed {
    logic fit;
    logic gt;
    logic match;
  } cell_flags_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0] block_addr;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_addr;
    logic [1:0] status;
    logic [CNT_OUT_W-1:0] free_blocks;
    logic [ADDR_W-1:0] free_bytes;
    logic [CNT_OUT_W-1:0] total_blocks;
    logic [ADDR_W-1:0] total_bytes;
    logic [ADDR_W-1:0] header_bytes;
  } rsp_t;
endpackage
`default_nettype wire

>>> design/ssba_cell.sv
// One table cell: holds a block's address, size and free mark.
// Compares against the request and takes data from its left neighbor. Uses ssba_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ssba_cell (
  input  wire logic clk,
  input  ssba_pkg::cell_op_t op,
  input  wire logic valid,
  input  wire logic [ssba_pkg::ADDR_W-1:0] left_addr,
  input  wire logic [ssba_pkg::SIZE_W-1:0] left_size,
  input  wire logic left_free,
  input  wire logic [ssba_pkg::ADDR_W-1:0] new_addr,
  input  wire logic [ssba_pkg::SIZE_W-1:0] req_size,
  input  wire logic [ssba_pkg::ADDR_W-1:0] req_addr,
  output logic [ssba_pkg::ADDR_W-1:0] addr,
  output logic [ssba_pkg::SIZE_W-1:0] size,
  output logic free,
  output ssba_pkg::cell_flags_t flags
);
  always_ff @(posedge clk) begin
    case (op)
      ssba_pkg::CELL_MARK_USED: free <= 1'b0;
      ssba_pkg::CELL_MARK_FREE: free <= 1'b1;
      ssba_pkg::CELL_LOAD_NEW: begin
        addr <= new_addr;
        size <= req_size;
        free <= 1'b0;
      end
      ssba_pkg::CELL_TAKE_LEFT: begin
        addr <= left_addr;
        size <= left_size;
        free <= left_free;
      end
      default: begin
      end
    endcase
  end

  assign flags.fit = valid && free && (size >= req_size);
  assign flags.gt = valid && (size > req_size);
  assign flags.match = valid && (addr == req_addr);
endmodule
`default_nettype wire

>>> design/size_sorted_block_allocator_unit.sv
// Top level of the size sorted block allocator: sequencer, totals and the cell row.
// Depends on ssba_pkg, ssba_cell and size_sorted_block_allocator_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "size_sorted_block_allocator_unit_macros.svh"
// The block keeps a table of heap blocks sorted by size in a row of cells and
// answers allocate, release and resize requests with one response item each.
// An item is accepted only while the sequencer is idle. Its response is loaded
// after a compare state that registers the flags of all cells and then a
// decision state that updates the row; a resize that moves a block must then
// free the old one in a further step. Only one item is in work at a time; the
// response register holds a finished item while the next one is accepted, and
// a stalled response holds the decision and free steps. Configuration writes
// are always ready.
module size_sorted_block_allocator_unit #(
  parameter int MAX_BLOCKS = ssba_pkg::DEF_MAX_BLOCKS,
  parameter int HEADER_BYTES = ssba_pkg::DEF_HEADER_BYTES
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic req_stall,
  input  ssba_pkg::req_t req,
  output logic rsp_valid,
  input  wire logic rsp_stall,
  output ssba_pkg::rsp_t rsp,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic cfg_index,
  input  wire logic [ssba_pkg::ADDR_W-1:0] cfg_data
);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int AW = ssba_pkg::ADDR_W;
  localparam int SW = ssba_pkg::SIZE_W;

  ssba_pkg::fsm_t state, state_next;
  ssba_pkg::req_t req_q;
  logic [AW-1:0] heap_limit, heap_top, heap_top_next;
  logic [CW-1:0] count, count_next, free_cnt, free_cnt_next;
  logic [AW-1:0] free_bytes, free_bytes_next, total_bytes, total_bytes_next;
  logic [AW-1:0] hdr_total, hdr_total_next;
  logic [MAX_BLOCKS-1:0] fit_q, gt_q, match_q, fit_oh, valid_v, stop;
  logic [SW-1:0] old_size, old_size_next;
  logic old_free, old_free_next;
  logic [AW-1:0] res_q, res_next;
  ssba_pkg::rsp_t rsp_next;
  logic rsp_load;
  logic out_free;

  logic [AW-1:0] c_addr [MAX_BLOCKS];
  logic [SW-1:0] c_size [MAX_BLOCKS];
  logic c_free [MAX_BLOCKS];
  ssba_pkg::cell_flags_t c_flags [MAX_BLOCKS];
  ssba_pkg::cell_op_t c_op [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] fit_v, gt_v, match_v;

  logic [AW-1:0] new_addr, fit_addr;
  logic [SW-1:0] fit_size;
  logic [AW:0] grow_end;
  logic bad_size, has_fit, grow_ok, has_match;

  genvar g;
  generate
    for (g = 0; g < MAX_BLOCKS; g++) begin : g_cell
      assign valid_v[g] = (CW'(g) < count);
      assign fit_v[g] = c_flags[g].fit;
      assign gt_v[g] = c_flags[g].gt;
      assign match_v[g] = c_flags[g].match;
      assign stop[g] = gt_q[g] || !valid_v[g];
      if (g == 0) begin : g_first
        ssba_cell u_cell (
          .clk(clk), .op(c_op[g]), .valid(valid_v[g]),
          .left_addr('0), .left_size('0), .left_free(1'b0),
          .new_addr(new_addr), .req_size(req_q.req_size), .req_addr(req_q.block_addr),
          .addr(c_addr[g]), .size(c_size[g]), .free(c_free[g]), .flags(c_flags[g])
        );
      end else begin : g_rest
        ssba_cell u_cell (
          .clk(clk), .op(c_op[g]), .valid(valid_v[g]),
          .left_addr(c_addr[g-1]), .left_size(c_size[g-1]), .left_free(c_free[g-1]),
          .new_addr(new_addr), .req_size(req_q.req_size), .req_addr(req_q.block_addr),
          .addr(c_addr[g]), .size(c_size[g]), .free(c_free[g]), .flags(c_flags[g])
        );
      end
    end
  endgenerate

  assign req_stall = (state != ssba_pkg::FSM_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free = !rsp_valid || !rsp_stall;
  assign fit_oh = fit_q & ((~fit_q) + {{(MAX_BLOCKS-1){1'b0}}, 1'b1});
  assign has_fit = |fit_q;
  assign has_match = |match_q;
  assign new_addr = heap_top + AW'(HEADER_BYTES);
  assign grow_end = {1'b0, heap_top} + (AW+1)'(req_q.req_size) + (AW+1)'(HEADER_BYTES);
  assign grow_ok = (count < CW'(MAX_BLOCKS)) && (grow_end <= {1'b0, heap_limit});
  assign bad_size = (req_q.req_size == '0) || (req_q.req_size > ssba_pkg::SIZE_CAP);

  always_comb begin
    fit_addr = '0;
    fit_size = '0;
    old_size_next = '0;
    old_free_next = 1'b0;
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      if (fit_oh[i]) begin
        fit_addr = fit_addr | c_addr[i];
        fit_size = fit_size | c_size[i];
      end
      if (match_v[i]) begin
        old_size_next = old_size_next | c_size[i];
        old_free_next = old_free_next | c_free[i];
      end
    end
  end

  always_comb begin
    logic try_alloc, then_free, done;
    logic [1:0] st;
    try_alloc = 1'b0;
    then_free = 1'b0;
    done = 1'b0;
    st = ssba_pkg::ST_OK;
    state_next = state;
    heap_top_next = heap_top;
    count_next = count;
    free_cnt_next = free_cnt;
    free_bytes_next = free_bytes;
    total_bytes_next = total_bytes;
    hdr_total_next = hdr_total;
    res_next = res_q;
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      c_op[i] = ssba_pkg::CELL_HOLD;
    end
    case (state)
      ssba_pkg::FSM_IDLE: begin
        if (req_valid) begin
          state_next = ssba_pkg::FSM_EVAL;
        end
      end
      ssba_pkg::FSM_EVAL: begin
        state_next = ssba_pkg::FSM_ACT;
      end
      ssba_pkg::FSM_ACT: begin
        if (out_free) begin
          res_next = '0;
          case (req_q.req_type)
            ssba_pkg::REQ_ALLOC: begin
              if (bad_size) begin
                st = ssba_pkg::ST_BAD_SIZE;
              end else begin
                try_alloc = 1'b1;
              end
            end
            ssba_pkg::REQ_RELEASE: begin
              if (req_q.block_addr == '0 || !has_match || old_free) begin
                st = ssba_pkg::ST_IGNORED;
              end else begin
                for (int i = 0; i < MAX_BLOCKS; i++) begin
                  if (match_q[i]) begin
                    c_op[i] = ssba_pkg::CELL_MARK_FREE;
                  end
                end
                free_cnt_next = free_cnt + 1'b1;
                free_bytes_next = free_bytes + AW'(old_size);
              end
            end
            ssba_pkg::REQ_RESIZE: begin
              if (bad_size) begin
                st = ssba_pkg::ST_BAD_SIZE;
              end else if (req_q.block_addr == '0) begin
                try_alloc = 1'b1;
              end else if (!has_match || old_free) begin
                st = ssba_pkg::ST_IGNORED;
              end else if (req_q.req_size <= old_size) begin
                res_next = req_q.block_addr;
              end else begin
                try_alloc = 1'b1;
                then_free = 1'b1;
              end
            end
            default: begin
              st = ssba_pkg::ST_IGNORED;
            end
          endcase
          if (try_alloc) begin
            if (has_fit) begin
              for (int i = 0; i < MAX_BLOCKS; i++) begin
                if (fit_oh[i]) begin
                  c_op[i] = ssba_pkg::CELL_MARK_USED;
                end
              end
              res_next = fit_addr;
              free_cnt_next = free_cnt - 1'b1;
              free_bytes_next = free_bytes - AW'(fit_size);
            end else if (grow_ok) begin
              for (int i = 0; i < MAX_BLOCKS; i++) begin
                if (stop[i] && (i == 0 || !stop[(i == 0) ? 0 : i-1])) begin
                  c_op[i] = ssba_pkg::CELL_LOAD_NEW;
                end else if (stop[i]) begin
                  c_op[i] = ssba_pkg::CELL_TAKE_LEFT;
                end
              end
              res_next = new_addr;
              count_next = count + 1'b1;
              total_bytes_next = total_bytes + AW'(req_q.req_size);
              hdr_total_next = hdr_total + AW'(HEADER_BYTES);
              heap_top_next = grow_end[AW-1:0];
            end else begin
              st = ssba_pkg::ST_NO_ROOM;
              then_free = 1'b0;
            end
          end
          if (then_free) begin
            state_next = ssba_pkg::FSM_FREE;
          end else begin
            state_next = ssba_pkg::FSM_IDLE;
            done = 1'b1;
          end
        end
      end
      ssba_pkg::FSM_FREE: begin
        if (out_free) begin
          for (int i = 0; i < MAX_BLOCKS; i++) begin
            if (match_v[i]) begin
              c_op[i] = ssba_pkg::CELL_MARK_FREE;
            end
          end
          free_cnt_next = free_cnt + 1'b1;
          free_bytes_next = free_bytes + AW'(old_size);
          state_next = ssba_pkg::FSM_IDLE;
          done = 1'b1;
        end
      end
      default: begin
        state_next = ssba_pkg::FSM_IDLE;
      end
    endcase
    rsp_load = done;
    rsp_next.result_addr = res_next;
    rsp_next.status = st;
    rsp_next.free_blocks = ssba_pkg::CNT_OUT_W'(free_cnt_next);
    rsp_next.free_bytes = free_bytes_next;
    rsp_next.total_blocks = ssba_pkg::CNT_OUT_W'(count_next);
    rsp_next.total_bytes = total_bytes_next;
    rsp_next.header_bytes = hdr_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssba_pkg::FSM_IDLE;
      heap_limit <= ssba_pkg::HEAP_LIMIT_RST;
      heap_top <= ssba_pkg::HEAP_BASE_RST;
      count <= '0;
      free_cnt <= '0;
      free_bytes <= '0;
      total_bytes <= '0;
      hdr_total <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      free_cnt <= free_cnt_next;
      free_bytes <= free_bytes_next;
      total_bytes <= total_bytes_next;
      hdr_total <= hdr_total_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready && cfg_index == ssba_pkg::CFG_HEAP_BASE && count == '0) begin
        heap_top <= cfg_data;
      end else begin
        heap_top <= heap_top_next;
      end
      if (cfg_valid && cfg_ready && cfg_index == ssba_pkg::CFG_HEAP_LIMIT) begin
        heap_limit <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ssba_pkg::FSM_IDLE && req_valid) begin
      req_q <= req;
    end
    if (state == ssba_pkg::FSM_EVAL) begin
      fit_q <= fit_v;
      gt_q <= gt_v;
      match_q <= match_v;
      old_size <= old_size_next;
      old_free <= old_free_next;
    end
    res_q <= res_next;
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  `SSBA_ASSERT_IMPL(a_count_max, 1'b1, count <= CW'(MAX_BLOCKS))
  `SSBA_ASSERT_IMPL(a_free_le_count, 1'b1, free_cnt <= count)
  `SSBA_ASSERT_NEXT(a_accept_eval, req_valid && !req_stall, state == ssba_pkg::FSM_EVAL)
endmodule
`default_nettype wire
